>>> rtl/bar_pkg.sv
// Shared types and constants for the block average ramp.
// Holds the payload structs, the block job record, divider handshake and back-end states.
// No dependencies.
package bar_pkg;

	// Field widths fixed by the interface
	localparam int SAMPLE_BITS    = 16;
	localparam int WIN_W          = 7;
	localparam int MAX_WINDOW_DEF = 64;
	localparam int MAX_WINDOW_LIM = 64;

	// Block sum holds up to MAX_WINDOW_LIM samples
	localparam int SUM_MAX_W = SAMPLE_BITS + $clog2(MAX_WINDOW_LIM);
	// Block mean: a block whose width is narrowed part-way can average past the sample range
	localparam int MEAN_W = SUM_MAX_W;
	// Divider dividend: block sum magnitude or mean difference magnitude scaled by 256
	localparam int DVD_W  = MEAN_W + 9;
	localparam int STEP_W = DVD_W + 1;
	localparam int ACC_W  = MEAN_W + 9;

	// Job queue depth between front and back
	localparam int FIFO_DEPTH = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_MODE  = 1'd1;
	localparam logic [WIN_W-1:0]     WINDOW_RESET     = 7'd4;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          end_of_stream;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          last_of_run;
	} out_t;

	// One completed block, handed from front to back
	typedef struct packed {
		logic signed [SUM_MAX_W-1:0]   sum;
		logic [WIN_W-1:0]              width;
		logic                          smooth;
		logic                          restart;
		logic signed [SAMPLE_BITS-1:0] first;
	} job_t;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [WIN_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DVD_W-1:0]  quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MEAN,
		BK_DIFF,
		BK_STEP,
		BK_EMIT
	} bk_state_t;

endpackage

>>> rtl/bar_div.sv
// Iterative unsigned divider, one quotient bit per cycle.
// Used by the back end for the block mean and the ramp step. Depends on bar_pkg.
module bar_div import bar_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [WIN_W-1:0] rem_q;
	logic [WIN_W-1:0] dvs_q;
	logic             done_q;
	logic             busy;
	logic [WIN_W:0]   shifted;
	logic             ge;

	assign busy    = (cnt_q != '0);
	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign ge      = (shifted >= {1'b0, dvs_q});

	// Control: bit counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (cnt_q == CNT_W'(1));
			if (req.start) begin
				cnt_q <= CNT_W'(DVD_W);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Datapath: restoring shift-subtract
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? WIN_W'(shifted - {1'b0, dvs_q}) : shifted[WIN_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> rtl/bar_fifo.sv
// Short job queue between the front and back ends.
// Registered entries, combinational head read. Depends on bar_pkg.
module bar_fifo import bar_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	job_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/bar_front.sv
// Front end: configuration registers, sample accumulation and block detection.
// Pushes one job per completed block into the queue. Depends on bar_pkg.
module bar_front import bar_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  job_push,
	output job_t                  job,
	input  logic                  job_full
);

	localparam int               CNT_W = $clog2(MAX_WINDOW + 1);
	localparam logic [WIN_W-1:0] MAXW  = WIN_W'(MAX_WINDOW);

	logic [WIN_W-1:0]              window_q;
	logic                          smooth_q;
	logic signed [SUM_MAX_W-1:0]   sum_q;
	logic [CNT_W-1:0]              count_q;
	logic                          pending_q;
	logic                          restart_q;
	logic signed [SAMPLE_BITS-1:0] first_q;

	logic [WIN_W-1:0]              w_eff;
	logic [CNT_W-1:0]              count_nxt;
	logic signed [SUM_MAX_W-1:0]   sum_nxt;
	logic                          complete;
	logic                          accept;

	// Effective width: zero acts as one, clamp to the maximum
	always_comb begin
		if (window_q == '0) begin
			w_eff = WIN_W'(1);
		end else if (window_q > MAXW) begin
			w_eff = MAXW;
		end else begin
			w_eff = window_q;
		end
	end

	assign count_nxt = count_q + 1'b1;
	assign sum_nxt   = sum_q + SUM_MAX_W'(in_data.sample);
	assign complete  = (WIN_W'(count_nxt) >= w_eff);
	assign in_stall  = job_full && complete;
	assign accept    = in_valid && !in_stall;
	assign job_push  = accept && complete;

	// Job record for the completed block
	always_comb begin
		job.sum     = sum_nxt;
		job.width   = w_eff;
		job.smooth  = smooth_q;
		job.restart = pending_q || restart_q;
		job.first   = pending_q ? in_data.sample : first_q;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			smooth_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW_WIDTH: window_q <= cfg_data[WIN_W-1:0];
				CFG_SMOOTH_MODE:  smooth_q <= cfg_data[0];
			endcase
		end
	end

	// Accumulator and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			count_q   <= '0;
			pending_q <= 1'b1;
			restart_q <= 1'b0;
		end else if (accept) begin
			if (in_data.end_of_stream) begin
				sum_q     <= '0;
				count_q   <= '0;
				pending_q <= 1'b1;
				restart_q <= 1'b0;
			end else if (complete) begin
				sum_q     <= '0;
				count_q   <= '0;
				pending_q <= 1'b0;
				restart_q <= 1'b0;
			end else begin
				sum_q     <= sum_nxt;
				count_q   <= count_nxt;
				pending_q <= 1'b0;
				restart_q <= pending_q || restart_q;
			end
		end
	end

	// First sample of a stream seeds the ramp
	always_ff @(posedge clk) begin
		if (accept && pending_q) begin
			first_q <= in_data.sample;
		end
	end

endmodule

>>> rtl/bar_back.sv
// Back end: per-block mean and, in smooth mode, ramp step through the shared divider, then result emission.
// Holds the previous mean and the output register. Depends on bar_pkg and bar_div.
module bar_back import bar_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t head,
	input  logic empty,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);

	bk_state_t state_q;
	bk_state_t state_nxt;

	job_t                          job_q;
	logic                          neg_q;
	logic signed [MEAN_W-1:0]      prev_q;
	logic signed [MEAN_W-1:0]      mean_q;
	logic signed [STEP_W-1:0]      step_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic [WIN_W-1:0]              k_q;
	logic                          out_valid_q;
	out_t                          out_q;

	div_req_t                      req;
	div_rsp_t                      rsp;
	logic                          emit;
	logic                          last;
	logic [SUM_MAX_W-1:0]          sum_mag;
	logic signed [MEAN_W:0]        diff;
	logic [MEAN_W:0]               diff_mag;
	logic [MEAN_W-1:0]             q_mean;

	bar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign sum_mag  = head.sum[SUM_MAX_W-1] ? SUM_MAX_W'(-head.sum) : SUM_MAX_W'(head.sum);
	assign diff     = (MEAN_W + 1)'(mean_q) - (MEAN_W + 1)'(prev_q);
	assign diff_mag = diff[MEAN_W] ? (MEAN_W + 1)'(-diff) : (MEAN_W + 1)'(diff);
	assign q_mean   = rsp.quotient[MEAN_W-1:0];
	assign last     = (k_q == job_q.width - 1'b1);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: if (!empty)    state_nxt = BK_MEAN;
			BK_MEAN: if (rsp.done)  state_nxt = job_q.smooth ? BK_DIFF : BK_EMIT;
			BK_DIFF:                state_nxt = BK_STEP;
			BK_STEP: if (rsp.done)  state_nxt = BK_EMIT;
			BK_EMIT: if (emit && last) state_nxt = BK_IDLE;
			default:                state_nxt = BK_IDLE;
		endcase
	end

	// Control outputs: queue pop, divider start, emission
	always_comb begin
		pop          = 1'b0;
		emit         = 1'b0;
		req.start    = 1'b0;
		req.dividend = DVD_W'({diff_mag, 8'd0});
		req.divisor  = job_q.width;
		unique case (state_q)
			BK_IDLE: begin
				pop          = !empty;
				req.start    = !empty;
				req.dividend = DVD_W'(sum_mag);
				req.divisor  = head.width;
			end
			BK_DIFF: req.start = 1'b1;
			BK_EMIT: emit      = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Block datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
			neg_q <= head.sum[SUM_MAX_W-1];
			if (head.restart) begin
				prev_q <= MEAN_W'(head.first);
			end
		end
		if (state_q == BK_MEAN && rsp.done) begin
			mean_q <= neg_q ? -q_mean : q_mean;
			k_q    <= '0;
		end
		if (state_q == BK_DIFF) begin
			neg_q <= diff[MEAN_W];
		end
		if (state_q == BK_STEP && rsp.done) begin
			step_q <= neg_q ? -STEP_W'(rsp.quotient) : STEP_W'(rsp.quotient);
			acc_q  <= ACC_W'(prev_q) <<< 8;
			prev_q <= mean_q;
		end
		if (emit) begin
			acc_q <= acc_q + ACC_W'(step_q);
			k_q   <= k_q + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.value       <= job_q.smooth ? acc_q[8 +: SAMPLE_BITS]
			                                  : mean_q[SAMPLE_BITS-1:0];
			out_q.last_of_run <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// The step division is only run for ramp blocks
	a_step_smooth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_STEP) |-> job_q.smooth)
		else $error("step division in hold mode");

	// The final result of a block returns the back end to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last) |=> (state_q == BK_IDLE))
		else $error("back end did not finish block on last result");

	// A block in progress never has a zero width
	a_width_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE) |-> (job_q.width != '0))
		else $error("zero block width in back end");

	// A fresh result is only loaded into a free or departing output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit)
		else $error("output transaction overwritten");
`endif

endmodule

>>> rtl/block_average_ramp.sv
// Top level of the block average ramp: front end, job queue and back end.
// Depends on bar_pkg, bar_front, bar_fifo and bar_back.
//
// Samples are taken one per cycle while the input is not stalled and summed over blocks of
// window_width samples. Each completed block becomes a job in a two-entry queue; the back end
// works out the mean and, in smooth mode, the ramp step with one shared divider that yields one
// quotient bit per cycle and flags completion from a register, then emits window_width results,
// one per cycle while the output is not stalled. The input stalls only when a sample would
// complete a block while the queue is full. Outputs are registered.
module block_average_ramp import bar_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic job_push;
	job_t job;
	logic job_full;
	logic job_pop;
	job_t job_head;
	logic job_empty;

	bar_front #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_push  (job_push),
		.job       (job),
		.job_full  (job_full)
	);

	bar_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job),
		.pop       (job_pop),
		.head      (job_head),
		.empty     (job_empty),
		.full      (job_full)
	);

	bar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (job_head),
		.empty     (job_empty),
		.pop       (job_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
